// File: src/ipv4dq_pkg.sv
package ipv4dq_pkg;

  // Character codes of interest
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // Octet limits
  localparam logic [11:0] OCTET_MAX     = 12'd255;
  localparam logic [1:0]  MAX_DIGITS    = 2'd3;
  localparam logic [1:0]  LAST_POSITION = 2'd3;

  // One character transaction as held in the input register
  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       empty_req;
  } item_t;

  // Input register towards the parse stage
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // Running parse state of the current string
  typedef struct packed {
    logic [7:0]  octet_value;
    logic [1:0]  digits_seen;
    logic [1:0]  octet_position;
    logic [23:0] gathered_octets;
    logic [4:0]  chars_seen;
    logic        failed;
  } parse_state_t;

endpackage

// File: src/ipv4dq_if.sv
// Character channel: one string character per transaction
interface ipv4dq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       empty_req;

  modport source (output valid, output character, output last, output empty_req,
                  input ready);
  modport sink (input valid, input character, input last, input empty_req,
                output ready);
endinterface

// Result channel: one parsed address per transaction
interface ipv4dq_result_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] address;

  modport source (output valid, output ok, output address, input ready);
  modport sink (input valid, input ok, input address, output ready);
endinterface

// File: src/ipv4dq_in_reg.sv
module ipv4dq_in_reg (
  input  logic                  clk,
  input  logic                  rst,
  ipv4dq_char_if.sink           chars,
  input  logic                  take,
  output ipv4dq_pkg::stage_t    stage
);

  logic                valid;
  ipv4dq_pkg::item_t   item;
  logic                accept;

  // Free when empty or when the held transaction moves on this cycle
  assign chars.ready = !valid || take;
  assign accept      = chars.valid && chars.ready;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item.character <= chars.character;
      item.last      <= chars.last;
      item.empty_req <= chars.empty_req;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

// File: src/ipv4dq_parse.sv
module ipv4dq_parse #(
  parameter int MAX_CHARS = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ipv4dq_pkg::stage_t    stage,
  output logic                  take,
  ipv4dq_result_if.source       result
);

  localparam logic [4:0] CHAR_LIMIT = 5'(MAX_CHARS);
  localparam logic [4:0] CHAR_SAT   = 5'(MAX_CHARS + 1);

  ipv4dq_pkg::parse_state_t state;
  ipv4dq_pkg::parse_state_t state_next;
  ipv4dq_pkg::parse_state_t stepped;

  logic        valid;
  logic        ok;
  logic [31:0] address;
  logic        ok_next;
  logic [31:0] address_next;
  logic        ends;
  logic        chars_full;
  logic        is_digit;
  logic [3:0]  digit;
  logic [7:0]  char_off;
  logic [11:0] value;

  // Take the held transaction unless a result is due and the slot is still full
  assign ends = stage.item.last || stage.item.empty_req;
  assign take = stage.valid && (!ends || !valid || result.ready);

  // Work out one character step
  always_comb begin
    stepped    = state;
    chars_full = state.chars_seen >= CHAR_LIMIT;
    char_off   = stage.item.character - ipv4dq_pkg::CHAR_ZERO;
    digit      = char_off[3:0];
    is_digit   = (stage.item.character >= ipv4dq_pkg::CHAR_ZERO) &&
                 (stage.item.character <= ipv4dq_pkg::CHAR_NINE);
    value      = {1'b0, state.octet_value, 3'b000} + {3'b000, state.octet_value, 1'b0} +
                 {8'd0, digit};

    if (chars_full) begin
      stepped.failed     = 1'b1;
      stepped.chars_seen = CHAR_SAT;
    end else begin
      stepped.chars_seen = state.chars_seen + 5'd1;
    end

    if (!stepped.failed) begin
      if (is_digit) begin
        if (state.digits_seen >= ipv4dq_pkg::MAX_DIGITS || value > ipv4dq_pkg::OCTET_MAX) begin
          stepped.failed = 1'b1;
        end else begin
          stepped.octet_value = value[7:0];
          stepped.digits_seen = state.digits_seen + 2'd1;
        end
      end else if (stage.item.character == ipv4dq_pkg::CHAR_DOT) begin
        if (state.digits_seen == 2'd0 || state.octet_position >= ipv4dq_pkg::LAST_POSITION) begin
          stepped.failed = 1'b1;
        end else begin
          stepped.gathered_octets = {state.gathered_octets[15:0], state.octet_value};
          stepped.octet_position  = state.octet_position + 2'd1;
          stepped.octet_value     = 8'd0;
          stepped.digits_seen     = 2'd0;
        end
      end else begin
        stepped.failed = 1'b1;
      end
    end
  end

  // Decide the result and the state left behind
  always_comb begin
    state_next   = stepped;
    ok_next      = 1'b0;
    address_next = 32'd0;
    if (stage.item.empty_req) begin
      state_next = '0;
    end else if (stage.item.last) begin
      ok_next = !stepped.failed && stepped.digits_seen != 2'd0 &&
                stepped.octet_position == ipv4dq_pkg::LAST_POSITION;
      if (ok_next) begin
        address_next = {stepped.gathered_octets, stepped.octet_value};
      end
      state_next = '0;
    end
  end

  // Advance the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take && ends) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ends) begin
      ok      <= ok_next;
      address <= address_next;
    end
  end

  assign result.valid   = valid;
  assign result.ok      = ok;
  assign result.address = address;

`ifndef SYNTHESIS
  a_chars_bounded: assert property (@(posedge clk) disable iff (rst)
    state.chars_seen <= CHAR_SAT)
    else $error("character count beyond saturation");

  a_value_needs_digits: assert property (@(posedge clk) disable iff (rst)
    state.digits_seen == 2'd0 |-> state.octet_value == 8'd0)
    else $error("octet value without digits");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(take) && $past(ends) |->
      state.chars_seen == 5'd0 && !state.failed && state.octet_position == 2'd0)
    else $error("state not cleared after string end");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    valid && !result.ready |-> !(take && ends))
    else $error("result overwritten while stalled");
`endif

endmodule

// File: src/ipv4_dotted_quad_parser_unit.sv
// Channel  Role    Payload                          Completes when
// chars    sink    character[7:0], last, empty_req  valid && ready
// result   source  ok, address[31:0]                valid && ready
//
// One character per cycle sustained unless an ending character waits on a stalled
// result; a result passes through the input register and then the result register.
// Reset (rst, synchronous) clears the parse state and both valid flags.
// A stalled result holds the next ending character in the input register;
// characters before it keep flowing, those after it wait until the result is taken.
module ipv4_dotted_quad_parser_unit #(
  parameter int MAX_CHARS = 15
) (
  input  logic              clk,
  input  logic              rst,
  ipv4dq_char_if.sink       chars,
  ipv4dq_result_if.source   result
);

  ipv4dq_pkg::stage_t stage;
  logic               take;

  ipv4dq_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .take  (take),
    .stage (stage)
  );

  ipv4dq_parse #(
    .MAX_CHARS (MAX_CHARS)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .stage  (stage),
    .take   (take),
    .result (result)
  );

endmodule

// File: sim/ipv4dq_checker.sv
`timescale 1ns / 1ps

// Watches both channels, models the parse and scores every result transaction
module ipv4dq_checker #(
  parameter int MAX_CHARS = 15
) (
  input  logic     clk,
  input  logic     rst,
  ipv4dq_char_if   chars,
  ipv4dq_result_if result,
  output int       mismatches,
  output int       pending
);

  localparam int DECIMAL_BASE = 10;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } parsed_address_t;

  // Addresses still owed by the block, oldest first
  parsed_address_t address_q[$];

  // Running parse of the current string
  logic [7:0]  octet_val;
  logic [1:0]  digits_held;
  logic [1:0]  dot_count;
  logic [23:0] octets_done;
  logic [4:0]  char_count;
  logic        bad;

  task automatic clear_parse();
    octet_val   = '0;
    digits_held = '0;
    dot_count   = '0;
    octets_done = '0;
    char_count  = '0;
    bad         = 1'b0;
  endtask

  // Advance the parse by one character
  task automatic take_character(input logic [7:0] c);
    int value;
    if (char_count >= MAX_CHARS) begin
      bad        = 1'b1;
      char_count = 5'(MAX_CHARS + 1);
    end else begin
      char_count = char_count + 5'd1;
    end
    // Once a string has failed, only the count moves on
    if (!bad) begin
      if (c >= ipv4dq_pkg::CHAR_ZERO && c <= ipv4dq_pkg::CHAR_NINE) begin
        value = int'(octet_val) * DECIMAL_BASE + int'(c - ipv4dq_pkg::CHAR_ZERO);
        if (digits_held >= ipv4dq_pkg::MAX_DIGITS || value > int'(ipv4dq_pkg::OCTET_MAX)) begin
          bad = 1'b1;
        end else begin
          octet_val   = 8'(value);
          digits_held = digits_held + 2'd1;
        end
      end else if (c == ipv4dq_pkg::CHAR_DOT) begin
        if (digits_held == '0 || dot_count >= ipv4dq_pkg::LAST_POSITION) begin
          bad = 1'b1;
        end else begin
          octets_done = {octets_done[15:0], octet_val};
          dot_count   = dot_count + 2'd1;
          octet_val   = '0;
          digits_held = '0;
        end
      end else begin
        bad = 1'b1;
      end
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    parsed_address_t want;
    if (rst) begin
      clear_parse();
      address_q.delete();
      mismatches = 0;
    end else begin
      // Score a completed result transaction against the oldest address owed
      if (result.valid && result.ready) begin
        if (address_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual ok=%b address=%h",
                   $time, result.ok, result.address);
        end else begin
          want = address_q.pop_front();
          if (result.ok !== want.ok)
            flag_mismatch("ok", 32'(want.ok), 32'(result.ok));
          if (result.address !== want.address)
            flag_mismatch("address", want.address, result.address);
        end
      end
      // Model each accepted character transaction
      if (chars.valid && chars.ready) begin
        if (chars.empty_req) begin
          address_q.push_back('0);
          clear_parse();
        end else begin
          take_character(chars.character);
          if (chars.last) begin
            want.ok      = !bad && digits_held != '0 &&
                           dot_count == ipv4dq_pkg::LAST_POSITION;
            want.address = want.ok ? {octets_done, octet_val} : '0;
            address_q.push_back(want);
            clear_parse();
          end
        end
      end
    end
    pending = address_q.size();
  end

endmodule

// File: sim/tb_ipv4_dotted_quad_parser_unit.sv
`timescale 1ns / 1ps

module tb_ipv4_dotted_quad_parser_unit;

  localparam int MAX_CHARS        = 15;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 8;

  typedef enum int {
    FLIP_CHAR, ADD_CHAR, DROP_CHAR, EXTRA_OCTET, EXTRA_DIGIT,
    CUT_SHORT, OVERLONG, DOUBLE_DOT, END_EMPTY
  } defect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Idling controls for the sender (send_idle) and the receiver (take_idle, long_hold_req)
  logic send_idle     = 1'b1;
  logic take_idle     = 1'b1;
  logic long_hold_req = 1'b0;

  int items_sent = 0;
  int mismatches;
  int pending;

  ipv4dq_char_if   chars_ch ();
  ipv4dq_result_if result_ch ();

  ipv4_dotted_quad_parser_unit #(
    .MAX_CHARS(MAX_CHARS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_ch),
    .result(result_ch)
  );

  ipv4dq_checker #(
    .MAX_CHARS(MAX_CHARS)
  ) parse_check (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars_ch),
    .result    (result_ch),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lean towards digits and dots so that strings get deep into the parse
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return ipv4dq_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    if (r < 70) return ipv4dq_pkg::CHAR_DOT;
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random holds, plus one long hold when asked
  initial begin
    int   hold_left;
    logic long_done;
    hold_left       = 0;
    long_done       = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_done) begin
        hold_left = LONG_HOLD_CYCLES;
        long_done = 1'b1;
      end else if (hold_left == 0 && take_idle) begin
        hold_left = gap_length();
      end
      if (hold_left > 0) begin
        result_ch.ready = 1'b0;
        hold_left--;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  // Offer one character transaction and hold it until taken
  task automatic send_item(input logic [7:0] c, input logic l, input logic e);
    int gap;
    gap = send_idle ? gap_length() : 0;
    if (gap > 0) begin
      @(negedge clk);
      chars_ch.valid     = 1'b0;
      chars_ch.character = 8'($urandom_range(0, 255));
      chars_ch.last      = 1'($urandom_range(0, 1));
      chars_ch.empty_req = 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    chars_ch.valid     = 1'b1;
    chars_ch.character = c;
    chars_ch.last      = l;
    chars_ch.empty_req = e;
    do @(posedge clk); while (!chars_ch.ready);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    chars_ch.valid = 1'b0;
  endtask

  // Send a string; close it with an empty request where asked or when it has no text
  task automatic send_text(ref logic [7:0] text[$], input logic end_empty);
    for (int i = 0; i < text.size(); i++)
      send_item(text[i], !end_empty && i == text.size() - 1, 1'b0);
    if (end_empty || text.size() == 0)
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Append an octet in decimal, optionally with leading zeros
  task automatic append_octet(ref logic [7:0] text[$], input int value, input logic pad);
    int width;
    int scale;
    width = value >= 100 ? 3 : (value >= 10 ? 2 : 1);
    if (pad) width = $urandom_range(width, 3);
    scale = 1;
    repeat (width - 1) scale = scale * 10;
    for (int i = 0; i < width; i++) begin
      text.push_back(ipv4dq_pkg::CHAR_ZERO + 8'((value / scale) % 10));
      scale = scale / 10;
    end
  endtask

  // Mostly well-formed addresses, some with one defect, the rest noise
  task automatic run_random_strings(input int target);
    logic [7:0] text[$];
    logic       end_empty;
    int         kind;
    int         pos;
    int         r;
    defect_t    defect;
    while (items_sent < target) begin
      text.delete();
      end_empty = 1'b0;
      kind      = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(0, 20)) text.push_back(pick_char());
      end else begin
        for (int i = 0; i < 4; i++) begin
          if (i > 0) text.push_back(ipv4dq_pkg::CHAR_DOT);
          r = $urandom_range(0, 99);
          append_octet(text, r < 15 ? 0 : (r < 30 ? 255 : $urandom_range(0, 255)),
                       $urandom_range(0, 3) == 0);
        end
        if (kind >= 60) begin
          pos    = $urandom_range(0, text.size() - 1);
          defect = defect_t'($urandom_range(0, END_EMPTY));
          case (defect)
            FLIP_CHAR:   text[pos] = 8'($urandom_range(0, 255));
            ADD_CHAR:    text.insert(pos, pick_char());
            DROP_CHAR:   text.delete(pos);
            EXTRA_OCTET: begin
              text.push_back(ipv4dq_pkg::CHAR_DOT);
              append_octet(text, $urandom_range(0, 255), 1'b0);
            end
            EXTRA_DIGIT: text.insert(pos, ipv4dq_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            CUT_SHORT:   while (text.size() > pos + 1) void'(text.pop_back());
            OVERLONG: begin
              if ($urandom_range(0, 1) == 1)
                while (text.size() <= MAX_CHARS) text.push_front(ipv4dq_pkg::CHAR_ZERO);
              else
                while (text.size() <= MAX_CHARS + 2) text.push_back(pick_char());
            end
            DOUBLE_DOT:  text.insert(pos, ipv4dq_pkg::CHAR_DOT);
            default:     end_empty = 1'b1;
          endcase
        end
      end
      send_text(text, end_empty);
    end
  endtask

  initial begin
    string quads[2];
    quads[0] = "0.0.0.0";
    quads[1] = "255.255.255.255";

    chars_ch.valid     = 1'b0;
    chars_ch.character = '0;
    chars_ch.last      = 1'b0;
    chars_ch.empty_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: smallest and largest address, empty string, lone bad byte, lone dot
    foreach (quads[q])
      for (int i = 0; i < quads[q].len(); i++)
        send_item(quads[q][i], i == quads[q].len() - 1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(ipv4dq_pkg::CHAR_DOT, 1'b1, 1'b0);

    run_random_strings(600);

    // Hold the result side off while characters keep coming back to back
    send_idle     = 1'b0;
    long_hold_req = 1'b1;
    run_random_strings(900);
    send_idle     = 1'b1;

    // Pause until every owed address has come out
    stop_sending();
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    // Stretch with no idling on either side, then random idling again
    send_idle = 1'b0;
    take_idle = 1'b0;
    run_random_strings(1200);
    send_idle = 1'b1;
    take_idle = 1'b1;
    run_random_strings(1800);

    stop_sending();
    for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
